@@ design/rdt_pkg.sv @@
// Shared types and codes for the reference-counted dedup table.
package rdt_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_META,
        S_EXEC
    } state_t;

    localparam logic [2:0] FN_LOOKUP  = 3'd0;
    localparam logic [2:0] FN_INSERT  = 3'd1;
    localparam logic [2:0] FN_ADDREF  = 3'd2;
    localparam logic [2:0] FN_RELEASE = 3'd3;
    localparam logic [2:0] FN_REMOVE  = 3'd4;
    localparam logic [2:0] FN_QUERY   = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISS     = 3'd1;
    localparam logic [2:0] ST_CONFLICT = 3'd2;
    localparam logic [2:0] ST_CORRUPT  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;
    localparam logic [2:0] ST_PRESENT  = 3'd5;
    localparam logic [2:0] ST_REFUSED  = 3'd6;
    localparam logic [2:0] ST_FULL     = 3'd7;

    localparam int BYTES_W = 54;

endpackage

@@ design/rdt_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module rdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/refcounted_dedup_table.sv @@
// Top level of the reference-counted, content-addressed dedup table.
//
// The slave channel (s_) carries one operation per transfer: the operation code
// in s_tuser and the 256-bit digest key plus the insert payload in s_tdata.
// The master channel (m_) returns exactly one result transfer per operation:
// the status code in m_tuser and the entry fields and table totals in m_tdata.
//
// Digests live in one RAM and the per-entry metadata in a second RAM. An
// operation scans the digest RAM one slot per cycle, pipelined behind the
// registered read, and stops at the first valid match. A hit then reads the
// metadata word, modifies it and writes it back in the execute cycle.
// A lookup of zero size or an undefined operation code skips the scan and goes
// straight to the execute state, while a miss or a new insert scans every slot.
// One operation is in flight at a time.
//
// Reset clears the valid marks, the entry count and the byte total at once,
// so no clearing pass is needed. If the receiver stalls, the result register
// holds its transfer, and the block may accept and process the next operation
// up to its execute cycle, where it waits for the result register to drain.
module refcounted_dedup_table
    import rdt_pkg::*;
#(
    parameter int ENTRIES   = 64,
    parameter int SIZE_BITS = 48,
    parameter int REF_BITS  = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // From bit 0: digest_word0, digest_word1, digest_word2, digest_word3,
    // content_size, new_blob_id, new_corrupt, new_generation, zero fill.
    input  logic [375:0] s_tdata,
    // From bit 0: func.
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // From bit 0: hit_blob_id, hit_size, hit_corrupt, hit_generation,
    // ref_count, entry_count, unique_bytes, zero fill.
    output logic [207:0] m_tdata,
    // From bit 0: status.
    output logic [2:0]   m_tuser
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int META_W = SIZE_BITS + 32 + 1 + 32 + REF_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    state_t state_reg, state_next;

    // Latched operation.
    logic [2:0]           func_reg, func_next;
    logic [255:0]         key_reg, key_next;
    logic [SIZE_BITS-1:0] size_reg, size_next;
    logic [31:0]          blob_in_reg, blob_in_next;
    logic                 cor_in_reg, cor_in_next;
    logic [31:0]          gen_in_reg, gen_in_next;

    // Scan control.
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic             issued_all_reg, issued_all_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             match_reg, match_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_reg, free_next;

    // Table totals and valid marks.
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;

    // Result register.
    logic               m_valid_reg, m_valid_next;
    logic [2:0]         status_out_reg, status_out_next;
    logic [31:0]        blob_out_reg, blob_out_next;
    logic [47:0]        size_out_reg, size_out_next;
    logic               cor_out_reg, cor_out_next;
    logic [31:0]        gen_out_reg, gen_out_next;
    logic [31:0]        ref_out_reg, ref_out_next;
    logic [6:0]         cnt_out_reg, cnt_out_next;
    logic [BYTES_W-1:0] bytes_out_reg, bytes_out_next;

    // RAM ports.
    logic               dig_we;
    logic [255:0]       dig_rdata;
    logic               meta_we;
    logic [IDX_W-1:0]   meta_waddr;
    logic [META_W-1:0]  meta_wdata;
    logic [META_W-1:0]  meta_rdata;

    // Input decode.
    logic [63:0]          sz64;
    logic [SIZE_BITS-1:0] size_in;
    logic                 in_accept;
    logic                 short_op;

    // Scan compare and result gating.
    logic cmp_hit;
    logic cmp_last;
    logic out_free;

    // Stored metadata fields.
    logic [SIZE_BITS-1:0] e_size;
    logic [31:0]          e_blob;
    logic                 e_cor;
    logic [31:0]          e_gen;
    logic [REF_BITS-1:0]  e_ref;

    // Execute-cycle values.
    logic [SIZE_BITS-1:0] r_size;
    logic [REF_BITS-1:0]  r_ref;
    logic [63:0]          hs64;
    logic [63:0]          hr64;

    assign sz64      = {16'b0, s_tdata[303:256]};
    assign size_in   = sz64[SIZE_BITS-1:0];
    assign in_accept = s_tvalid && s_tready;
    assign short_op  = (s_tuser > FN_QUERY) ||
                       ((s_tuser == FN_LOOKUP) && (size_in == '0));

    assign cmp_hit  = cmp_vld_reg && valid_reg[cmp_idx_reg] && (dig_rdata == key_reg);
    assign cmp_last = (cmp_idx_reg == LAST_IDX);
    assign out_free = !m_valid_reg || m_tready;

    assign e_size = meta_rdata[SIZE_BITS-1:0];
    assign e_blob = meta_rdata[SIZE_BITS +: 32];
    assign e_cor  = meta_rdata[SIZE_BITS + 32];
    assign e_gen  = meta_rdata[SIZE_BITS + 33 +: 32];
    assign e_ref  = meta_rdata[SIZE_BITS + 65 +: REF_BITS];

    rdt_ram #(.WIDTH(256), .DEPTH(ENTRIES)) u_digest_ram (
        .clk   (aclk),
        .we    (dig_we),
        .waddr (free_reg),
        .wdata (key_reg),
        .raddr (scan_reg),
        .rdata (dig_rdata)
    );

    rdt_ram #(.WIDTH(META_W), .DEPTH(ENTRIES)) u_meta_ram (
        .clk   (aclk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (slot_reg),
        .rdata (meta_rdata)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = short_op ? S_EXEC : S_SCAN;
                end
            end
            S_SCAN: begin
                if (cmp_hit) begin
                    state_next = S_META;
                end else if (cmp_vld_reg && cmp_last) begin
                    state_next = S_EXEC;
                end
            end
            S_META: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        s_tready = (state_reg == S_IDLE);
    end

    // Datapath: scan bookkeeping and the read-modify-write of one entry.
    always_comb begin
        func_next       = func_reg;
        key_next        = key_reg;
        size_next       = size_reg;
        blob_in_next    = blob_in_reg;
        cor_in_next     = cor_in_reg;
        gen_in_next     = gen_in_reg;
        scan_next       = scan_reg;
        issued_all_next = issued_all_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        match_next      = match_reg;
        slot_next       = slot_reg;
        free_found_next = free_found_reg;
        free_next       = free_reg;
        valid_next      = valid_reg;
        cnt_next        = cnt_reg;
        bytes_next      = bytes_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        status_out_next = status_out_reg;
        blob_out_next   = blob_out_reg;
        size_out_next   = size_out_reg;
        cor_out_next    = cor_out_reg;
        gen_out_next    = gen_out_reg;
        ref_out_next    = ref_out_reg;
        cnt_out_next    = cnt_out_reg;
        bytes_out_next  = bytes_out_reg;
        dig_we          = 1'b0;
        meta_we         = 1'b0;
        meta_waddr      = slot_reg;
        meta_wdata      = meta_rdata;
        r_size          = e_size;
        r_ref           = e_ref;
        hs64            = '0;
        hr64            = '0;

        if (in_accept) begin
            func_next       = s_tuser;
            key_next        = s_tdata[255:0];
            size_next       = size_in;
            blob_in_next    = s_tdata[335:304];
            cor_in_next     = s_tdata[336];
            gen_in_next     = s_tdata[368:337];
            scan_next       = '0;
            issued_all_next = 1'b0;
            match_next      = 1'b0;
            free_found_next = 1'b0;
        end

        if (state_reg == S_SCAN) begin
            cmp_vld_next = !issued_all_reg;
            cmp_idx_next = scan_reg;
            if (!issued_all_reg) begin
                if (scan_reg == LAST_IDX) begin
                    issued_all_next = 1'b1;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            if (cmp_vld_reg) begin
                if (cmp_hit) begin
                    match_next = 1'b1;
                    slot_next  = cmp_idx_reg;
                end else if (!valid_reg[cmp_idx_reg] && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_next       = cmp_idx_reg;
                end
            end
        end

        if ((state_reg == S_EXEC) && out_free) begin
            status_out_next = ST_OK;
            m_valid_next    = 1'b1;
            if (func_reg > FN_QUERY) begin
                status_out_next = ST_REFUSED;
            end else if (!match_reg) begin
                status_out_next = ST_MISS;
                if (func_reg == FN_INSERT) begin
                    if (free_found_reg) begin
                        status_out_next = ST_OK;
                        r_size          = size_reg;
                        r_ref           = REF_BITS'(1);
                        dig_we          = 1'b1;
                        meta_we         = 1'b1;
                        meta_waddr      = free_reg;
                        meta_wdata      = {r_ref, gen_in_reg, cor_in_reg, blob_in_reg, size_reg};
                        valid_next[free_reg] = 1'b1;
                        cnt_next        = cnt_reg + 1'b1;
                        bytes_next      = bytes_reg + BYTES_W'(size_reg);
                    end else begin
                        status_out_next = ST_FULL;
                    end
                end
            end else begin
                case (func_reg)
                    FN_LOOKUP: begin
                        if (e_size != size_reg) begin
                            status_out_next = ST_CONFLICT;
                        end else if (e_cor) begin
                            status_out_next = ST_CORRUPT;
                        end
                    end
                    FN_INSERT: begin
                        status_out_next = (e_size == size_reg) ? ST_PRESENT : ST_CONFLICT;
                    end
                    FN_ADDREF: begin
                        if (e_cor) begin
                            status_out_next = ST_CORRUPT;
                        end else if (e_ref == {REF_BITS{1'b1}}) begin
                            status_out_next = ST_OVERFLOW;
                        end else begin
                            r_ref      = e_ref + 1'b1;
                            meta_we    = 1'b1;
                            meta_wdata = {r_ref, e_gen, e_cor, e_blob, e_size};
                        end
                    end
                    FN_RELEASE: begin
                        if (e_ref == '0) begin
                            status_out_next = ST_REFUSED;
                        end else begin
                            r_ref      = e_ref - 1'b1;
                            meta_we    = 1'b1;
                            meta_wdata = {r_ref, e_gen, e_cor, e_blob, e_size};
                        end
                    end
                    FN_REMOVE: begin
                        if (e_ref != '0) begin
                            status_out_next = ST_REFUSED;
                        end else begin
                            valid_next[slot_reg] = 1'b0;
                            cnt_next   = cnt_reg - 1'b1;
                            bytes_next = bytes_reg - BYTES_W'(e_size);
                        end
                    end
                    default: begin
                        status_out_next = ST_OK;
                    end
                endcase
            end

            hs64 = 64'(r_size);
            hr64 = 64'(r_ref);
            if (match_reg || ((func_reg == FN_INSERT) && free_found_reg)) begin
                blob_out_next = match_reg ? e_blob : blob_in_reg;
                cor_out_next  = match_reg ? e_cor : cor_in_reg;
                gen_out_next  = match_reg ? e_gen : gen_in_reg;
                size_out_next = hs64[47:0];
                ref_out_next  = hr64[31:0];
            end else begin
                blob_out_next = '0;
                cor_out_next  = 1'b0;
                gen_out_next  = '0;
                size_out_next = '0;
                ref_out_next  = '0;
            end
            // Undefined operation codes never scanned, so their entry fields are forced to zero.
            if (func_reg > FN_QUERY) begin
                blob_out_next = '0;
                cor_out_next  = 1'b0;
                gen_out_next  = '0;
                size_out_next = '0;
                ref_out_next  = '0;
            end
            cnt_out_next   = 7'(cnt_next);
            bytes_out_next = bytes_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            cnt_reg        <= '0;
            bytes_reg      <= '0;
            m_valid_reg    <= 1'b0;
            match_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            issued_all_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            cnt_reg        <= cnt_next;
            bytes_reg      <= bytes_next;
            m_valid_reg    <= m_valid_next;
            match_reg      <= match_next;
            free_found_reg <= free_found_next;
            cmp_vld_reg    <= cmp_vld_next;
            issued_all_reg <= issued_all_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        key_reg        <= key_next;
        size_reg       <= size_next;
        blob_in_reg    <= blob_in_next;
        cor_in_reg     <= cor_in_next;
        gen_in_reg     <= gen_in_next;
        scan_reg       <= scan_next;
        cmp_idx_reg    <= cmp_idx_next;
        slot_reg       <= slot_next;
        free_reg       <= free_next;
        status_out_reg <= status_out_next;
        blob_out_reg   <= blob_out_next;
        size_out_reg   <= size_out_next;
        cor_out_reg    <= cor_out_next;
        gen_out_reg    <= gen_out_next;
        ref_out_reg    <= ref_out_next;
        cnt_out_reg    <= cnt_out_next;
        bytes_out_reg  <= bytes_out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_out_reg;
    assign m_tdata  = {2'b0, bytes_out_reg, cnt_out_reg, ref_out_reg, gen_out_reg,
                       cor_out_reg, size_out_reg, blob_out_reg};

endmodule

@@ bench/rdt_checker.sv @@
// Checker for the dedup table: it predicts each result from the input transfers and compares.
module rdt_checker
    import rdt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [375:0] s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [207:0] m_tdata,
    input  logic [2:0]   m_tuser,
    output int           fail_count,
    output int           pending_results
);

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] blob_id;
        logic [47:0] size;
        logic        corrupt;
        logic [31:0] generation;
        logic [31:0] refs;
        logic [6:0]  entries;
        logic [53:0] bytes;
    } outcome_t;

    localparam int SLOTS = 64;
    localparam logic [31:0] REF_MAX = 32'hFFFF_FFFF;

    // Shadow copy of the table.
    logic         slot_used  [SLOTS];
    logic [255:0] slot_key   [SLOTS];
    logic [47:0]  slot_size  [SLOTS];
    logic [31:0]  slot_blob  [SLOTS];
    logic         slot_bad   [SLOTS];
    logic [31:0]  slot_gen   [SLOTS];
    logic [31:0]  slot_refs  [SLOTS];
    logic [6:0]   live_entries;
    logic [53:0]  live_bytes;

    outcome_t expected_outcomes[$];

    function automatic outcome_t run_operation(input logic [2:0] fn, input logic [255:0] key,
                                               input logic [47:0] sz, input logic [31:0] bid,
                                               input logic bad, input logic [31:0] gen);
        outcome_t r;
        int match;
        int slot;
        int spare;
        bit gone;
        r = '0;
        match = -1;
        slot = -1;
        spare = -1;
        gone = 0;
        r.status = ST_OK;
        if (fn > FN_QUERY) begin
            r.status = ST_REFUSED;
        end else if (fn == FN_LOOKUP && sz == '0) begin
            r.status = ST_MISS;
        end else begin
            for (int i = SLOTS - 1; i >= 0; i--) begin
                if (slot_used[i] && slot_key[i] == key) match = i;
                if (!slot_used[i]) spare = i;
            end
            slot = match;
            if (fn == FN_INSERT) begin
                if (match >= 0) begin
                    r.status = (slot_size[match] == sz) ? ST_PRESENT : ST_CONFLICT;
                end else if (spare < 0) begin
                    r.status = ST_FULL;
                end else begin
                    slot_used[spare] = 1'b1;
                    slot_key[spare]  = key;
                    slot_size[spare] = sz;
                    slot_blob[spare] = bid;
                    slot_bad[spare]  = bad;
                    slot_gen[spare]  = gen;
                    slot_refs[spare] = 32'd1;
                    live_entries = live_entries + 7'd1;
                    live_bytes   = live_bytes + 54'(sz);
                    slot = spare;
                end
            end else if (match < 0) begin
                r.status = ST_MISS;
            end else begin
                case (fn)
                    FN_LOOKUP: begin
                        if (slot_size[match] != sz) r.status = ST_CONFLICT;
                        else if (slot_bad[match]) r.status = ST_CORRUPT;
                    end
                    FN_ADDREF: begin
                        if (slot_bad[match]) r.status = ST_CORRUPT;
                        else if (slot_refs[match] == REF_MAX) r.status = ST_OVERFLOW;
                        else slot_refs[match] = slot_refs[match] + 32'd1;
                    end
                    FN_RELEASE: begin
                        if (slot_refs[match] == '0) r.status = ST_REFUSED;
                        else slot_refs[match] = slot_refs[match] - 32'd1;
                    end
                    FN_REMOVE: begin
                        if (slot_refs[match] != '0) begin
                            r.status = ST_REFUSED;
                        end else begin
                            slot_used[match] = 1'b0;
                            live_entries = live_entries - 7'd1;
                            live_bytes   = live_bytes - 54'(slot_size[match]);
                            gone = 1;
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (slot >= 0) begin
            r.blob_id    = slot_blob[slot];
            r.size       = slot_size[slot];
            r.corrupt    = slot_bad[slot];
            r.generation = slot_gen[slot];
            r.refs       = gone ? '0 : slot_refs[slot];
        end
        r.entries = live_entries;
        r.bytes   = live_bytes;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        outcome_t want;
        outcome_t got;
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
            live_entries = '0;
            live_bytes = '0;
            expected_outcomes.delete();
            fail_count = 0;
        end else begin
            // Results leave before the operation that is accepted at this edge can finish.
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[31:0], m_tdata[79:32], m_tdata[80], m_tdata[112:81],
                       m_tdata[144:113], m_tdata[151:145], m_tdata[205:152]};
                if (expected_outcomes.size() == 0) begin
                    $error("Result transfer with no operation outstanding");
                    fail_count++;
                end else begin
                    want = expected_outcomes.pop_front();
                    compare_field("status", 64'(want.status), 64'(got.status));
                    compare_field("hit_blob_id", 64'(want.blob_id), 64'(got.blob_id));
                    compare_field("hit_size", 64'(want.size), 64'(got.size));
                    compare_field("hit_corrupt", 64'(want.corrupt), 64'(got.corrupt));
                    compare_field("hit_generation", 64'(want.generation),
                                  64'(got.generation));
                    compare_field("ref_count", 64'(want.refs), 64'(got.refs));
                    compare_field("entry_count", 64'(want.entries), 64'(got.entries));
                    compare_field("unique_bytes", 64'(want.bytes), 64'(got.bytes));
                end
                if (m_tdata[207:206] !== 2'b00) begin
                    $error("zero fill mismatch: expected 0, actual %0h", m_tdata[207:206]);
                    fail_count++;
                end
            end
            if (s_tvalid && s_tready) begin
                expected_outcomes.push_back(run_operation(s_tuser, s_tdata[255:0],
                    s_tdata[303:256], s_tdata[335:304], s_tdata[336], s_tdata[368:337]));
            end
        end
        pending_results = expected_outcomes.size();
    end

endmodule

@@ bench/tb_refcounted_dedup_table.sv @@
// Testbench top for the dedup table: stimulus, handshake pacing and the final verdict.
module tb_refcounted_dedup_table;
    import rdt_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // From bit 0: digest_word0, digest_word1, digest_word2, digest_word3,
    // content_size, new_blob_id, new_corrupt, new_generation, zero fill.
    logic [375:0] s_tdata;
    // From bit 0: func.
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // From bit 0: hit_blob_id, hit_size, hit_corrupt, hit_generation,
    // ref_count, entry_count, unique_bytes, zero fill.
    logic [207:0] m_tdata;
    // From bit 0: status.
    logic [2:0]   m_tuser;

    int fail_count;
    int pending_results;

    // The stimulus asks once for a long receiver hold-off; the receiver marks it done.
    logic hold_request;
    logic hold_done;

    localparam int KEYS = 96;
    logic [255:0] key_pool  [KEYS];
    logic [47:0]  size_pool [KEYS];
    int burst_left;

    refcounted_dedup_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    rdt_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // The run is cut off well past the slowest correct finish.
    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: alternates between always-ready stretches and random stalls,
    // and honors one long hold-off so that the table backs up into the input.
    initial begin
        int cycle;
        bit steady;
        cycle = 0;
        steady = 1'b0;
        hold_done <= 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            cycle++;
            if (cycle % 64 == 0) steady = ($urandom_range(0, 2) == 0);
            if (hold_request && !hold_done) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_done <= 1'b1;
            end else if (steady) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 9) < 6);
            end
        end
    end

    // Offers one operation and returns at the edge where its transfer takes place.
    // The sender runs in bursts; between bursts valid may drop for a random gap.
    task automatic send_op(input logic [2:0] fn, input int key_idx, input logic [47:0] sz,
                           input logic [31:0] bid, input logic bad, input logic [31:0] gen);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {7'b0, gen, bad, bid, sz, key_pool[key_idx]};
        // Ready is sampled mid-cycle, where it is stable, and the transfer lands on the
        // following rising edge.
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
    endtask

    // Sends with a fresh random payload for the insert-only fields.
    task automatic send_random_payload(input logic [2:0] fn, input int key_idx,
                                       input logic [47:0] sz);
        send_op(fn, key_idx, sz, $urandom, ($urandom_range(0, 6) == 0), $urandom);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_results != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    initial begin
        int roll;
        int k;
        logic [2:0] fn;
        logic [47:0] sz;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        hold_request <= 1'b0;
        burst_left = 0;

        key_pool[0]  = '0;
        key_pool[1]  = '1;
        size_pool[0] = 48'd1;
        size_pool[1] = '1;
        for (int i = 2; i < KEYS; i++) begin
            key_pool[i] = {$urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom};
            size_pool[i] = 48'({$urandom, $urandom});
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: extremes of the fields and every status but overflow and full.
        send_op(FN_INSERT, 0, 48'd1, 32'd0, 1'b0, 32'd0);
        send_op(FN_INSERT, 1, '1, '1, 1'b1, '1);
        send_op(FN_INSERT, 0, 48'd1, 32'd7, 1'b0, 32'd7);        // already present
        send_op(FN_INSERT, 0, 48'd2, 32'd7, 1'b0, 32'd7);        // size conflict
        send_op(FN_LOOKUP, 0, 48'd0, 32'd0, 1'b0, 32'd0);        // zero size misses
        send_op(FN_LOOKUP, 0, 48'd1, 32'd0, 1'b0, 32'd0);        // hit
        send_op(FN_LOOKUP, 0, 48'd5, 32'd0, 1'b0, 32'd0);        // conflict
        send_op(FN_LOOKUP, 1, '1, 32'd0, 1'b0, 32'd0);           // corrupt entry
        send_op(FN_LOOKUP, 2, size_pool[2], '0, 1'b0, '0);       // miss
        send_op(FN_ADDREF, 0, '0, '0, 1'b0, '0);
        send_op(FN_ADDREF, 1, '0, '0, 1'b0, '0);                 // corrupt entry
        send_op(FN_ADDREF, 2, '0, '0, 1'b0, '0);                 // not found
        send_op(FN_RELEASE, 0, '0, '0, 1'b0, '0);
        send_op(FN_RELEASE, 0, '0, '0, 1'b0, '0);
        send_op(FN_RELEASE, 0, '0, '0, 1'b0, '0);                // release at zero
        send_op(FN_REMOVE, 1, '0, '0, 1'b0, '0);                 // still referenced
        send_op(FN_REMOVE, 0, '0, '0, 1'b0, '0);                 // orphan removed
        send_op(FN_REMOVE, 0, '0, '0, 1'b0, '0);                 // not found
        send_op(FN_QUERY, 1, '0, '0, 1'b0, '0);
        send_op(FN_QUERY, 2, '0, '0, 1'b0, '0);
        send_op(3'd6, 1, '1, '1, 1'b1, '1);                      // undefined codes
        send_op(3'd7, 0, '0, '0, 1'b0, '0);
        send_op(FN_INSERT, 2, 48'd0, 32'h5A5A_A5A5, 1'b0, 32'h0F0F_F0F0);
        send_op(FN_LOOKUP, 2, 48'd0, '0, 1'b0, '0);

        // Let every result come back before the sender resumes.
        drain_results();

        // Fill the table past capacity; the receiver holds off meanwhile so the
        // input side backs up.
        hold_request <= 1'b1;
        for (int i = 3; i < 72; i++) begin
            send_random_payload(FN_INSERT, i, size_pool[i]);
        end

        // Random mix over a key pool small enough that keys keep recurring.
        for (int n = 0; n < 360; n++) begin
            k = $urandom_range(0, KEYS - 1);
            roll = $urandom_range(0, 99);
            if (roll < 25) fn = FN_INSERT;
            else if (roll < 45) fn = FN_LOOKUP;
            else if (roll < 57) fn = FN_ADDREF;
            else if (roll < 77) fn = FN_RELEASE;
            else if (roll < 92) fn = FN_REMOVE;
            else if (roll < 97) fn = FN_QUERY;
            else fn = 3'($urandom_range(6, 7));
            roll = $urandom_range(0, 19);
            if (roll < 16) sz = size_pool[k];
            else if (roll < 18) sz = 48'({$urandom, $urandom});
            else if (roll < 19) sz = '0;
            else sz = '1;
            send_random_payload(fn, k, sz);
        end

        drain_results();
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
